### sv/assert_macros.svh
// Assertion macros for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A condition that holds at every clock edge outside reset.
`define PIDFD_ASSERT(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("pidfd assertion failed");

// A consequence that holds in the same cycle as its cause.
`define PIDFD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pidfd assertion failed");

// A consequence that holds in the cycle after its cause.
`define PIDFD_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pidfd assertion failed");

`else

`define PIDFD_ASSERT(name, clk, rst_n, expr)
`define PIDFD_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define PIDFD_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

### sv/pidfd_pkg.sv
// Shared constants, codes and types of the filtered-derivative PID controller.
package pidfd_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int P_GAIN_W = 24;
    localparam int I_COEF_W = 32;
    localparam int D_GAIN_W = 32;
    localparam int D_POLE_W = 18;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // Fraction bits of the Q.16 and Q.24 formats.
    localparam int Q16_FRAC = 16;
    localparam int Q24_FRAC = 24;

    // Integrator in Q3.24, limited to plus or minus five.
    localparam int INTEG_W   = 28;
    localparam int INTEG_MAX = 5 * (1 << 24);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_P_GAIN  = 3'd0,
        CFG_I_COEF  = 3'd1,
        CFG_D_GAIN  = 3'd2,
        CFG_D_POLE  = 3'd3,
        CFG_OUT_MIN = 3'd4,
        CFG_OUT_MAX = 3'd5
    } cfg_idx_t;

    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_CLEAR  = 1'b1
    } op_t;

    typedef struct packed {
        logic signed [P_GAIN_W-1:0] p_gain;
        logic signed [I_COEF_W-1:0] i_coef;
        logic signed [D_GAIN_W-1:0] d_gain;
        logic signed [D_POLE_W-1:0] d_pole;
    } coef_t;

    typedef struct packed {
        logic valid;
        logic clear;
    } stage_ctl_t;

endpackage

### sv/pidfd_sample_if.sv
// Input channel: one update or clear item per handshake.
interface pidfd_sample_if import pidfd_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
    logic                           valid;
    logic                           ready;
    op_t                            opcode;
    logic signed [SAMPLE_WIDTH-1:0] setpoint;
    logic signed [SAMPLE_WIDTH-1:0] measured;

    modport source (output valid, output opcode, output setpoint, output measured, input ready);
    modport sink   (input valid, input opcode, input setpoint, input measured, output ready);
endinterface

### sv/pidfd_result_if.sv
// Output channel: one drive value per handshake.
interface pidfd_result_if import pidfd_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

### sv/pidfd_cfg_if.sv
// Configuration write channel: register index and write data.
interface pidfd_cfg_if import pidfd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/pidfd_cfg.sv
// Configuration register file: coefficients and output limits.
module pidfd_cfg import pidfd_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    pidfd_cfg_if.sink                      cfg,
    output coef_t                          coef,
    output logic signed [SAMPLE_WIDTH-1:0] out_min,
    output logic signed [SAMPLE_WIDTH-1:0] out_max
);

    coef_t                          coef_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_min_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_max_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg    <= '0;
            out_min_reg <= {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
            out_max_reg <= {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_P_GAIN:  coef_reg.p_gain <= cfg.data[P_GAIN_W-1:0];
                CFG_I_COEF:  coef_reg.i_coef <= cfg.data[I_COEF_W-1:0];
                CFG_D_GAIN:  coef_reg.d_gain <= cfg.data[D_GAIN_W-1:0];
                CFG_D_POLE:  coef_reg.d_pole <= cfg.data[D_POLE_W-1:0];
                CFG_OUT_MIN: out_min_reg     <= cfg.data[SAMPLE_WIDTH-1:0];
                CFG_OUT_MAX: out_max_reg     <= cfg.data[SAMPLE_WIDTH-1:0];
                default:     ;
            endcase
        end
    end

    assign coef    = coef_reg;
    assign out_min = out_min_reg;
    assign out_max = out_max_reg;

endmodule

### sv/pidfd_update.sv
// Input register, controller state and the per-item state update.
module pidfd_update import pidfd_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    pidfd_sample_if.sink                    sample,
    input  coef_t                           coef,
    input  logic                            b_free,
    output stage_ctl_t                      a_ctl,
    output logic signed [SAMPLE_WIDTH+2:0]  a_prop,
    output logic signed [INTEG_W-1:0]       integral,
    output logic signed [SAMPLE_WIDTH+15:0] deriv
);

    localparam int W      = SAMPLE_WIDTH;
    localparam int ERR_W  = W + 1;
    localparam int ESUM_W = W + 2;
    localparam int PROP_W = W + 3;
    localparam int DACC_W = W + 16;
    localparam int PP_W   = P_GAIN_W + ERR_W;
    localparam int PQ_W   = PP_W - Q16_FRAC;
    localparam int IP_W   = I_COEF_W + ESUM_W;
    localparam int IS_W   = IP_W + 1;
    localparam int PL_W   = D_POLE_W + DACC_W;
    localparam int PT_W   = PL_W - Q16_FRAC;
    localparam int DP_W   = D_GAIN_W + ERR_W;
    localparam int DN_W   = ((PT_W > DP_W) ? PT_W : DP_W) + 1;

    localparam logic signed [PP_W-1:0] P_BIAS   = (PP_W'(1) << Q16_FRAC) - PP_W'(1);
    localparam logic signed [PQ_W-1:0] PLIM_POS = PQ_W'(1) << (W + 1);
    localparam logic signed [PQ_W-1:0] PLIM_NEG = -PLIM_POS;
    localparam logic signed [IS_W-1:0] I_HI     = IS_W'(INTEG_MAX);
    localparam logic signed [IS_W-1:0] I_LO     = -I_HI;
    localparam logic signed [DN_W-1:0] D_HI     = (DN_W'(1) << (DACC_W - 1)) - DN_W'(1);
    localparam logic signed [DN_W-1:0] D_LO     = -(DN_W'(1) << (DACC_W - 1));

    logic                      s_valid_reg;
    op_t                       s_op_reg;
    logic signed [W-1:0]       s_sp_reg;
    logic signed [W-1:0]       s_ms_reg;

    logic                      a_valid_reg;
    logic                      a_clear_reg;
    logic signed [PROP_W-1:0]  a_prop_reg;
    logic signed [PROP_W-1:0]  a_prop_next;

    logic signed [INTEG_W-1:0] integral_reg;
    logic signed [INTEG_W-1:0] integral_next;
    logic signed [ERR_W-1:0]   last_err_reg;
    logic signed [W-1:0]       last_meas_reg;
    logic signed [DACC_W-1:0]  deriv_reg;
    logic signed [DACC_W-1:0]  deriv_next;

    logic                      a_free;
    logic                      s_free;
    logic                      s_move;

    logic signed [ERR_W-1:0]   error;
    logic signed [ESUM_W-1:0]  esum;
    logic signed [ERR_W-1:0]   dmeas;
    logic signed [PP_W-1:0]    p_prod;
    logic signed [PP_W-1:0]    p_adj;
    logic signed [PQ_W-1:0]    p_quot;
    logic signed [PQ_W-1:0]    p_clamp;
    logic signed [IP_W-1:0]    i_prod;
    logic signed [IS_W-1:0]    i_sum;
    logic signed [IS_W-1:0]    i_clamp;
    logic signed [PL_W-1:0]    pl_prod;
    logic signed [PT_W-1:0]    pole_term;
    logic signed [DP_W-1:0]    dg_prod;
    logic signed [DN_W-1:0]    d_new;
    logic signed [DN_W-1:0]    d_clamp;

    // Each stage moves on when the one after it is empty or emptying.
    assign a_free       = !a_valid_reg || b_free;
    assign s_free       = !s_valid_reg || a_free;
    assign s_move       = s_valid_reg && a_free;
    assign sample.ready = s_free;

    assign error = ERR_W'(s_sp_reg) - ERR_W'(s_ms_reg);
    assign esum  = ESUM_W'(error) + ESUM_W'(last_err_reg);
    assign dmeas = ERR_W'(s_ms_reg) - ERR_W'(last_meas_reg);

    // Proportional part, rounded toward zero.
    assign p_prod = PP_W'($signed(coef.p_gain)) * PP_W'(error);
    assign p_adj  = p_prod + (p_prod[PP_W-1] ? P_BIAS : '0);
    assign p_quot = $signed(p_adj[PP_W-1:Q16_FRAC]);

    // Trapezoidal integrator step.
    assign i_prod = IP_W'($signed(coef.i_coef)) * IP_W'(esum);
    assign i_sum  = IS_W'(integral_reg) + IS_W'(i_prod);

    // Filtered derivative; dropping the low bits floors the pole product.
    assign pl_prod   = PL_W'($signed(coef.d_pole)) * PL_W'(deriv_reg);
    assign pole_term = $signed(pl_prod[PL_W-1:Q16_FRAC]);
    assign dg_prod   = DP_W'($signed(coef.d_gain)) * DP_W'(dmeas);
    assign d_new     = DN_W'(pole_term) - DN_W'(dg_prod);

    always_comb
    begin
        priority if (p_quot > PLIM_POS)
            p_clamp = PLIM_POS;
        else if (p_quot < PLIM_NEG)
            p_clamp = PLIM_NEG;
        else
            p_clamp = p_quot;

        priority if (i_sum > I_HI)
            i_clamp = I_HI;
        else if (i_sum < I_LO)
            i_clamp = I_LO;
        else
            i_clamp = i_sum;

        priority if (d_new > D_HI)
            d_clamp = D_HI;
        else if (d_new < D_LO)
            d_clamp = D_LO;
        else
            d_clamp = d_new;

        a_prop_next   = $signed(p_clamp[PROP_W-1:0]);
        integral_next = $signed(i_clamp[INTEG_W-1:0]);
        deriv_next    = $signed(d_clamp[DACC_W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg   <= 1'b0;
            a_valid_reg   <= 1'b0;
            a_clear_reg   <= 1'b0;
            integral_reg  <= '0;
            last_err_reg  <= '0;
            deriv_reg     <= '0;
            last_meas_reg <= '0;
        end
        else
        begin
            if (s_free)
                s_valid_reg <= sample.valid;
            if (a_free)
                a_valid_reg <= s_valid_reg;
            if (s_move)
            begin
                a_clear_reg <= (s_op_reg == OP_CLEAR);
                if (s_op_reg == OP_CLEAR)
                begin
                    integral_reg  <= '0;
                    last_err_reg  <= '0;
                    deriv_reg     <= '0;
                    last_meas_reg <= '0;
                end
                else
                begin
                    integral_reg  <= integral_next;
                    last_err_reg  <= error;
                    deriv_reg     <= deriv_next;
                    last_meas_reg <= s_ms_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_free && sample.valid)
        begin
            s_op_reg <= sample.opcode;
            s_sp_reg <= sample.setpoint;
            s_ms_reg <= sample.measured;
        end
        if (s_move)
            a_prop_reg <= a_prop_next;
    end

    // The state registers hold the values left by the item now in this stage.
    assign a_ctl.valid = a_valid_reg;
    assign a_ctl.clear = a_clear_reg;
    assign a_prop      = a_prop_reg;
    assign integral    = integral_reg;
    assign deriv       = deriv_reg;

endmodule

### sv/pidfd_combine.sv
// Sum of the three parts, saturation, output limits and the result register.
module pidfd_combine import pidfd_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  stage_ctl_t                      a_ctl,
    input  logic signed [SAMPLE_WIDTH+2:0]  a_prop,
    input  logic signed [INTEG_W-1:0]       integral,
    input  logic signed [SAMPLE_WIDTH+15:0] deriv,
    input  logic signed [SAMPLE_WIDTH-1:0]  out_min,
    input  logic signed [SAMPLE_WIDTH-1:0]  out_max,
    output logic                            b_free,
    pidfd_result_if.source                  result
);

    localparam int W     = SAMPLE_WIDTH;
    localparam int SUM_W = W + 28;
    localparam int Q_W   = SUM_W - Q24_FRAC;

    localparam logic signed [SUM_W-1:0] SUM_BIAS = (SUM_W'(1) << Q24_FRAC) - SUM_W'(1);
    localparam logic signed [Q_W-1:0]   S_MAX    = (Q_W'(1) << (W - 1)) - Q_W'(1);
    localparam logic signed [Q_W-1:0]   S_MIN    = -(Q_W'(1) << (W - 1));

    logic                   out_valid_reg;
    logic signed [W-1:0]    drive_reg;
    logic signed [W-1:0]    drive_next;

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] sum_adj;
    logic signed [Q_W-1:0]   quot;
    logic signed [Q_W-1:0]   sat_q;
    logic signed [W-1:0]     sat;

    // All three parts aligned to Q.24, then rounded toward zero.
    assign sum     = (SUM_W'(a_prop) <<< Q24_FRAC) + SUM_W'(integral)
                   + (SUM_W'(deriv) <<< (Q24_FRAC - Q16_FRAC));
    assign sum_adj = sum + (sum[SUM_W-1] ? SUM_BIAS : '0);
    assign quot    = $signed(sum_adj[SUM_W-1:Q24_FRAC]);

    always_comb
    begin
        priority if (quot > S_MAX)
            sat_q = S_MAX;
        else if (quot < S_MIN)
            sat_q = S_MIN;
        else
            sat_q = quot;
        sat = $signed(sat_q[W-1:0]);

        // Inverted limits: above out_max gives out_max, all else gives out_min.
        priority if (a_ctl.clear)
            drive_next = '0;
        else if (sat > out_max)
            drive_next = out_max;
        else if (sat < out_min)
            drive_next = out_min;
        else
            drive_next = sat;
    end

    assign b_free = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (b_free)
            out_valid_reg <= a_ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (b_free && a_ctl.valid)
            drive_reg <= drive_next;
    end

    assign result.valid = out_valid_reg;
    assign result.drive = drive_reg;

endmodule

### sv/pid_controller_filtered_derivative_top.sv
// Top level of the PID controller with trapezoidal integrator and filtered derivative.
//
// The block takes items on the sample channel and returns one drive value for each
// item on the result channel, in order. An update item carries a setpoint and a
// measurement; a clear item zeroes the integrator, the derivative filter and the
// stored error and measurement, and returns a drive of zero.
// Coefficients and output limits are written on the cfg channel, one register per
// item, by index. The channel is always ready. Write it only while no item is in
// flight; the new values apply to the next item accepted.
// Throughput is one item per clock while the receiver takes results. The state
// loop (pole multiply, subtract and saturate for the derivative, multiply-add and
// clamp for the integrator) closes within the state-update stage, so consecutive
// items never wait on each other. An accepted item passes the input register, the
// state-update stage, then the sum, saturation and limit stage into the output
// register, from which it is presented on the result channel.
// When the receiver stalls, the result is held and the stages behind it keep
// filling; the sample channel drops ready only when all three stages hold items.
// Reset clears the pipeline and the controller state, zeroes the gains and sets
// the output limits to the full signed sample range.
//
`include "assert_macros.svh"
module pid_controller_filtered_derivative_top import pidfd_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    pidfd_sample_if.sink   sample,
    pidfd_result_if.source result,
    pidfd_cfg_if.sink      cfg
);

    coef_t                          coef;
    logic signed [SAMPLE_WIDTH-1:0] out_min;
    logic signed [SAMPLE_WIDTH-1:0] out_max;
    stage_ctl_t                     a_ctl;
    logic signed [SAMPLE_WIDTH+2:0] a_prop;
    logic signed [INTEG_W-1:0]      integral;
    logic signed [SAMPLE_WIDTH+15:0] deriv;
    logic                           b_free;

    logic                           integ_ok;
    logic                           clear_in_a;
    logic                           clear_moving;

    // Register file for the coefficients and limits.
    pidfd_cfg #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .coef    (coef),
        .out_min (out_min),
        .out_max (out_max)
    );

    // Input register and the state-update stage of the controller.
    pidfd_update #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_update (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (sample),
        .coef     (coef),
        .b_free   (b_free),
        .a_ctl    (a_ctl),
        .a_prop   (a_prop),
        .integral (integral),
        .deriv    (deriv)
    );

    // Final sum and clamps, feeding the output register.
    pidfd_combine #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_combine (
        .clk      (clk),
        .rst_n    (rst_n),
        .a_ctl    (a_ctl),
        .a_prop   (a_prop),
        .integral (integral),
        .deriv    (deriv),
        .out_min  (out_min),
        .out_max  (out_max),
        .b_free   (b_free),
        .result   (result)
    );

    assign integ_ok     = (integral <= $signed(INTEG_W'(INTEG_MAX)))
                       && (integral >= -$signed(INTEG_W'(INTEG_MAX)));
    assign clear_in_a   = a_ctl.valid && a_ctl.clear;
    assign clear_moving = clear_in_a && b_free;

    // The integrator never leaves its clamp range.
    `PIDFD_ASSERT(a_integ_range, clk, rst_n, integ_ok)
    // A clear item in the update stage has left all filter state at zero.
    `PIDFD_ASSERT_IMP(a_clear_state, clk, rst_n, clear_in_a, (integral == '0) && (deriv == '0))
    // The input side only stalls when a finished result is being held back.
    `PIDFD_ASSERT_IMP(a_stall_cause, clk, rst_n, !sample.ready, result.valid && !result.ready)
    // A clear item moving to the output gives a zero drive.
    `PIDFD_ASSERT_NXT(a_clear_drive, clk, rst_n, clear_moving, result.valid && (result.drive == '0))

endmodule
